### design/ise_pkg.sv
// Shared types and constants for the insertion sort engine.
// No dependencies; every other design file imports this package.
package ise_pkg;

    localparam int unsigned STAT_W = 11;
    localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};

    typedef struct packed {
        logic [15:0] value;
        logic        last_in;
    } ise_in_t;

    typedef struct packed {
        logic [15:0]       sorted_value;
        logic              last_out;
        logic [STAT_W-1:0] comparison_count;
        logic [STAT_W-1:0] shift_count;
        logic              dropped;
    } ise_out_t;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } ise_cell_ctl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_DRAIN
    } ise_state_t;

endpackage

### design/ise_cell.sv
// One compare-and-shift cell of the sorting chain.
// Depends on ise_pkg for the cell control struct.
module ise_cell import ise_pkg::*; #(
    parameter int unsigned DATA_WIDTH = 16
) (
    input  logic                  aclk,
    input  ise_cell_ctl_t         ctl,
    input  logic [DATA_WIDTH-1:0] key,
    input  logic                  in_range,
    input  logic [DATA_WIDTH-1:0] left_val,
    input  logic                  left_gt,
    input  logic [DATA_WIDTH-1:0] right_val,
    output logic [DATA_WIDTH-1:0] val,
    output logic                  gt
);

    logic [DATA_WIDTH-1:0] val_reg;

    // An empty cell acts as +infinity, so the new key lands there.
    assign gt  = !in_range || (val_reg > key);
    assign val = val_reg;

    always_ff @(posedge aclk) begin
        if (ctl.insert) begin
            if (gt) begin
                val_reg <= left_gt ? left_val : key;
            end
        end else if (ctl.shift_out) begin
            val_reg <= right_val;
        end
    end

endmodule

### design/ise_tally.sv
// Comparison and shift totals, derived from the chain's greater-than vector.
// Depends on ise_pkg for the statistic width and saturation limit.
module ise_tally import ise_pkg::*; #(
    parameter int unsigned MAX_ELEMS = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             insert,
    input  logic [MAX_ELEMS-1:0]             gt_vec,
    input  logic [$clog2(MAX_ELEMS+1)-1:0]   count_in,
    input  logic                             clear,
    output logic [STAT_W-1:0]                comparisons,
    output logic [STAT_W-1:0]                shifts,
    output logic                             busy
);

    localparam int unsigned CNTW = $clog2(MAX_ELEMS + 1);
    localparam int unsigned IDXW = $clog2(MAX_ELEMS);
    localparam int unsigned PADN = 1 << IDXW;
    localparam int unsigned SUMW = ((CNTW > STAT_W) ? CNTW : STAT_W) + 1;

    logic                 v1_reg;
    logic                 v2_reg;
    logic [MAX_ELEMS-1:0] gt_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [CNTW-1:0]      shift_inc_reg;
    logic [CNTW-1:0]      cmp_inc_reg;
    logic [STAT_W-1:0]    cmp_acc_reg;
    logic [STAT_W-1:0]    shf_acc_reg;

    logic [PADN-1:0]      pad;
    logic [IDXW-1:0]      zpos;
    logic [IDXW-1:0]      cand;
    logic [CNTW-1:0]      shift_inc;
    logic [CNTW-1:0]      cmp_inc;
    logic [SUMW-1:0]      cmp_sum;
    logic [SUMW-1:0]      shf_sum;

    // Pad past the store with ones so the vector stays monotone.
    for (genvar i = 0; i < PADN; i++) begin : g_pad
        if (i < MAX_ELEMS) begin : g_real
            assign pad[i] = gt_reg[i];
        end else begin : g_fill
            assign pad[i] = 1'b1;
        end
    end

    // Binary search for the first greater-than cell: that is the insert point.
    always_comb begin
        zpos = '0;
        cand = '0;
        for (int b = IDXW - 1; b >= 0; b--) begin
            cand = zpos | (IDXW'(1) << b);
            if (!pad[cand - 1'b1]) begin
                zpos = cand;
            end
        end
        shift_inc = cnt_reg - CNTW'(zpos);
        cmp_inc   = shift_inc + CNTW'(zpos != '0);
    end

    assign cmp_sum = SUMW'(cmp_acc_reg) + SUMW'(cmp_inc_reg);
    assign shf_sum = SUMW'(shf_acc_reg) + SUMW'(shift_inc_reg);

    always_ff @(posedge aclk) begin
        gt_reg        <= insert ? gt_vec : gt_reg;
        cnt_reg       <= insert ? count_in : cnt_reg;
        shift_inc_reg <= shift_inc;
        cmp_inc_reg   <= cmp_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            cmp_acc_reg <= '0;
            shf_acc_reg <= '0;
        end else begin
            v1_reg <= insert;
            v2_reg <= v1_reg;
            if (clear) begin
                cmp_acc_reg <= '0;
                shf_acc_reg <= '0;
            end else if (v2_reg) begin
                // Saturate at the top of the statistic range.
                cmp_acc_reg <= (cmp_sum > SUMW'(STAT_MAX)) ? STAT_MAX : cmp_sum[STAT_W-1:0];
                shf_acc_reg <= (shf_sum > SUMW'(STAT_MAX)) ? STAT_MAX : shf_sum[STAT_W-1:0];
            end
        end
    end

    assign comparisons = cmp_acc_reg;
    assign shifts      = shf_acc_reg;
    assign busy        = v1_reg || v2_reg;

endmodule

### design/insertion_sort_engine_core.sv
// Insertion sort engine: loads a run of elements and returns them sorted.
//
// Input channel s_valid/s_ready/s_item carries one element per transfer;
// s_item.last_in closes the run. Each element is inserted into a chain of
// MAX_ELEMS compare-and-shift cells in the cycle it is transferred, and
// s_ready stays high for the whole load phase. Elements beyond MAX_ELEMS are
// discarded and flagged on every result of the run through m_item.dropped.
// After the last element, the settle state waits until the tally pipeline
// has summed the comparison and shift totals, then the chain drains from its
// head one result per cycle on m_valid/m_ready/m_item while the receiver is
// ready. The final result has last_out set and carries the totals, saturated
// at 2047. s_ready stays low from the last input transfer until the final
// result is loaded into the output register.
// A stalled receiver holds the output register and freezes the drain.
// Reset (aresetn low, synchronous) empties the chain, clears the totals and
// the overflow flag, and drops any pending result.
module insertion_sort_engine_core import ise_pkg::*; #(
    parameter int unsigned MAX_ELEMS  = 64,
    parameter int unsigned DATA_WIDTH = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  ise_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output ise_out_t m_item
);

    localparam int unsigned CNTW = $clog2(MAX_ELEMS + 1);

    ise_state_t            state_reg;
    ise_state_t            state_next;
    logic [CNTW-1:0]       count_reg;
    logic                  overflow_reg;
    logic                  m_valid_reg;
    ise_out_t              m_item_reg;

    logic                  accept;
    logic                  full;
    logic                  insert;
    logic                  drain_load;
    logic                  drain_final;
    logic                  tally_busy;
    logic [STAT_W-1:0]     comparisons;
    logic [STAT_W-1:0]     shifts;
    logic [DATA_WIDTH-1:0] key;
    ise_cell_ctl_t         cell_ctl;

    logic [DATA_WIDTH-1:0] vals [MAX_ELEMS];
    logic [MAX_ELEMS-1:0]  gts;

    assign key  = DATA_WIDTH'(s_item.value);
    assign full = (count_reg == CNTW'(MAX_ELEMS));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept && s_item.last_in) begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: begin
                if (!tally_busy) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_final) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        drain_load = 1'b0;
        case (state_reg)
            ST_LOAD:   s_ready    = 1'b1;
            ST_SETTLE: s_ready    = 1'b0;
            ST_DRAIN:  drain_load = !m_valid_reg || m_ready;
            default:   s_ready    = 1'b0;
        endcase
    end

    assign accept             = s_valid && s_ready;
    assign insert             = accept && !full;
    assign drain_final        = drain_load && (count_reg == CNTW'(1));
    assign cell_ctl.insert    = insert;
    assign cell_ctl.shift_out = drain_load;

    for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_chain
        logic [DATA_WIDTH-1:0] left_val;
        logic                  left_gt;
        logic [DATA_WIDTH-1:0] right_val;

        if (i == 0) begin : g_head
            assign left_val = key;
            assign left_gt  = 1'b0;
        end else begin : g_body
            assign left_val = vals[i-1];
            assign left_gt  = gts[i-1];
        end

        if (i == MAX_ELEMS - 1) begin : g_tail
            assign right_val = vals[i];
        end else begin : g_mid
            assign right_val = vals[i+1];
        end

        ise_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (cell_ctl),
            .key       (key),
            .in_range  (count_reg > CNTW'(i)),
            .left_val  (left_val),
            .left_gt   (left_gt),
            .right_val (right_val),
            .val       (vals[i]),
            .gt        (gts[i])
        );
    end

    ise_tally #(
        .MAX_ELEMS(MAX_ELEMS)
    ) u_tally (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .insert      (insert),
        .gt_vec      (gts),
        .count_in    (count_reg),
        .clear       (drain_final),
        .comparisons (comparisons),
        .shifts      (shifts),
        .busy        (tally_busy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (insert) begin
                count_reg <= count_reg + 1'b1;
            end else if (drain_load) begin
                count_reg <= count_reg - 1'b1;
            end
            if (drain_final) begin
                overflow_reg <= 1'b0;
            end else if (accept && full) begin
                overflow_reg <= 1'b1;
            end
            if (drain_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Load the head of the chain; the totals ride only on the final transfer.
    always_ff @(posedge aclk) begin
        if (drain_load) begin
            m_item_reg.sorted_value     <= 16'(vals[0]);
            m_item_reg.last_out         <= drain_final;
            m_item_reg.comparison_count <= drain_final ? comparisons : '0;
            m_item_reg.shift_count      <= drain_final ? shifts : '0;
            m_item_reg.dropped          <= overflow_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### design/ise_checker.sv
// Port-level checks for insertion_sort_engine_core, bound to the top level.
// Depends on ise_pkg for the channel payload types.
module ise_checker import ise_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input ise_in_t  s_item,
    input logic     m_valid,
    input logic     m_ready,
    input ise_out_t m_item
);

    // Hold a stalled result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
    else $error("result changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.last_out |->
            m_item.comparison_count == '0 && m_item.shift_count == '0)
    else $error("totals on a non-final result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.last_out |-> m_item.comparison_count >= m_item.shift_count)
    else $error("fewer comparisons than shifts");

    // No input transfer while a run is still draining.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.last_out |-> !s_ready)
    else $error("input ready in the middle of a drain");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
    else $error("result valid after reset");

endmodule

bind insertion_sort_engine_core ise_checker u_ise_checker (.*);

### tb/sv/insertion_sort_engine_core_tb.sv
// Self-checking testbench for insertion_sort_engine_core: drives runs of elements,
// predicts the sorted output with comparison and shift totals, and checks every result.
// Depends on ise_pkg and the insertion_sort_engine_core RTL.
`timescale 1ns / 1ps

module insertion_sort_engine_core_tb;
    import ise_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int RANDOM_ITEMS = 30;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;
    localparam int HOLD_CYCLES  = 400;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ise_in_t  s_item = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ise_out_t m_item;

    insertion_sort_engine_core #(
        .MAX_ELEMS (CAPACITY),
        .DATA_WIDTH(16)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item (s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item (m_item)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    ise_in_t     element_feed[$];
    ise_out_t    expected_sorted[$];
    logic [15:0] run_elems[$];
    logic        run_overflow = 1'b0;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  items_queued = 0;
    int  items_accepted = 0;
    int  results_seen = 0;
    int  runs_sorted = 0;
    int  overflow_runs = 0;
    int  errors = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  s_xfer = 1'b0;

    function automatic logic [STAT_W-1:0] saturate(int n);
        return (n > int'(STAT_MAX)) ? STAT_MAX : STAT_W'(n);
    endfunction

    // Stable straight insertion on the current run, then queue one result per element.
    function automatic void sort_run();
        logic [15:0] arr[$];
        logic [15:0] key;
        ise_out_t    res;
        int          hole;
        int          cmp;
        int          shf;
        arr = run_elems;
        cmp = 0;
        shf = 0;
        for (int pos = 1; pos < arr.size(); pos++) begin
            key  = arr[pos];
            hole = pos;
            while (hole > 0 && arr[hole-1] > key) begin
                arr[hole] = arr[hole-1];
                cmp++;
                shf++;
                hole--;
            end
            if (hole > 0) cmp++;
            arr[hole] = key;
        end
        for (int k = 0; k < arr.size(); k++) begin
            res.sorted_value     = arr[k];
            res.last_out         = (k == arr.size() - 1);
            res.comparison_count = res.last_out ? saturate(cmp) : '0;
            res.shift_count      = res.last_out ? saturate(shf) : '0;
            res.dropped          = run_overflow;
            expected_sorted.push_back(res);
        end
        runs_sorted++;
        if (run_overflow) overflow_runs++;
        run_elems.delete();
        run_overflow = 1'b0;
    endfunction

    function automatic void load_element(ise_in_t item);
        if (run_elems.size() < CAPACITY) run_elems.push_back(item.value);
        else run_overflow = 1'b1;
        if (item.last_in) sort_run();
    endfunction

    // Driver: present the next element once the current one has been transferred.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_xfer) begin
            if (element_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_item  <= element_feed.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, once, while the sender keeps offering elements.
    always @(negedge aclk) begin
        if (!hold_done && results_seen >= 10) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: feed accepted elements to the predictor, check each result transfer.
    always @(posedge aclk) begin : monitor
        ise_out_t want;
        if (!aresetn) begin
            s_xfer <= 1'b0;
        end else begin
            s_xfer <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                items_accepted++;
                load_element(s_item);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_sorted.size() == 0) begin
                    $error("unexpected result: sorted_value %0d", m_item.sorted_value);
                    errors++;
                end else begin
                    want = expected_sorted.pop_front();
                    if (m_item.sorted_value !== want.sorted_value) begin
                        $error("sorted_value expected %0d got %0d",
                               want.sorted_value, m_item.sorted_value);
                        errors++;
                    end
                    if (m_item.last_out !== want.last_out) begin
                        $error("last_out expected %0d got %0d", want.last_out, m_item.last_out);
                        errors++;
                    end
                    if (m_item.comparison_count !== want.comparison_count) begin
                        $error("comparison_count expected %0d got %0d",
                               want.comparison_count, m_item.comparison_count);
                        errors++;
                    end
                    if (m_item.shift_count !== want.shift_count) begin
                        $error("shift_count expected %0d got %0d",
                               want.shift_count, m_item.shift_count);
                        errors++;
                    end
                    if (m_item.dropped !== want.dropped) begin
                        $error("dropped expected %0d got %0d", want.dropped, m_item.dropped);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic push_element(logic [15:0] value, logic last);
        ise_in_t item;
        item.value   = value;
        item.last_in = last;
        element_feed.push_back(item);
        items_queued++;
    endtask

    // Bias toward duplicates and extremes so stability and edge values get exercised.
    function automatic logic [15:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return 16'($urandom_range(0, 7));
        if (r < 32) return 16'h0000;
        if (r < 39) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    task automatic push_run(int len);
        for (int i = 0; i < len; i++) push_element(pick_value(), i == len - 1);
    endtask

    task automatic push_random_runs(int budget);
        int start;
        int r;
        start = items_queued;
        while (items_queued - start < budget) begin
            r = $urandom_range(0, 99);
            if (r < 70) push_run($urandom_range(1, 12));
            else if (r < 88) push_run($urandom_range(13, 40));
            else if (r < 94) push_run($urandom_range(60, CAPACITY));
            else push_run($urandom_range(CAPACITY + 1, CAPACITY + 8));
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (items_accepted != items_queued || expected_sorted.size() != 0);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // single element, two-element orders, duplicates, full descent and ascent
        push_element(16'hFFFF, 1'b1);
        push_element(16'h0000, 1'b0);
        push_element(16'hFFFF, 1'b1);
        push_element(16'hFFFF, 1'b0);
        push_element(16'h0000, 1'b1);
        push_element(16'd5, 1'b0);
        push_element(16'd3, 1'b0);
        push_element(16'd5, 1'b0);
        push_element(16'd3, 1'b0);
        push_element(16'd5, 1'b1);
        for (int i = 8; i >= 1; i--) push_element(16'(i), i == 1);
        for (int i = 1; i <= 4; i++) push_element(16'(i), i == 4);
        // exactly full, last arriving at a full store, and several drops
        push_run(CAPACITY);
        push_run(CAPACITY + 1);
        push_run(CAPACITY + 6);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            push_random_runs(RANDOM_ITEMS);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("Sorted %0d runs from %0d elements; %0d results checked, %0d runs dropped input.",
                 runs_sorted, items_accepted, results_seen, overflow_runs);
        if (errors == 0 && expected_sorted.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
